>>> rtl/core/decimal_int64_parser_top_defines.svh
// Assertion macros shared by the parser RTL.
// DIP_ASSERT expects signals named clk and rst_n in its scope; DIP_ASSERT_ALWAYS needs only clk.
`ifndef DECIMAL_INT64_PARSER_TOP_DEFINES_SVH
`define DECIMAL_INT64_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked outside of reset only.
`define DIP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dip assertion failed");
// Checked at every edge, reset included.
`define DIP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dip assertion failed");
`else
`define DIP_ASSERT(lbl, prop)
`define DIP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> rtl/core/dip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dip_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned MAG_W  = 64;
    localparam int unsigned CNT_W  = 5;

    localparam logic [CNT_W-1:0]  MAX_DIGITS  = 5'd20;
    localparam logic [BYTE_W-1:0] CH_MINUS    = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE     = 8'h39;
    localparam logic [MAG_W-1:0]  MAG_POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [MAG_W-1:0]  MAG_NEG_MAX = 64'h8000_0000_0000_0000;

    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_SIGN     = 3'd1,
        PH_ZERO     = 3'd2,
        PH_DIGITS   = 3'd3,
        PH_FAILWAIT = 3'd4,
        PH_SKIP     = 3'd5
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } item_t;

    typedef struct packed {
        logic              ok;
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [CNT_W-1:0]  consumed;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/dip_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module dip_in_reg
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       byte_in,
    input  wire logic             end_of_buffer,
    input  wire logic             advance,
    output logic                  item_valid,
    output dip_pkg::item_t        item
);

    logic           valid_reg;
    logic           valid_next;
    dip_pkg::item_t item_reg;

    // Take a new byte when empty or when the held byte moves on this cycle.
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.data <= byte_in;
            item_reg.last <= end_of_buffer;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

>>> rtl/core/dip_parse.sv
`timescale 1ns / 1ps
`default_nettype none
`include "decimal_int64_parser_top_defines.svh"

module dip_parse
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  wire dip_pkg::item_t  item,
    input  wire logic            out_free,
    output logic                 advance,
    output logic                 emit,
    output dip_pkg::result_t     res
);

    dip_pkg::phase_t                  phase_reg;
    dip_pkg::phase_t                  phase_next;
    logic [dip_pkg::MAG_W-1:0]        mag_reg;
    logic [dip_pkg::MAG_W-1:0]        mag_next;
    logic                             neg_reg;
    logic                             neg_next;
    logic [dip_pkg::CNT_W-1:0]        cnt_reg;
    logic [dip_pkg::CNT_W-1:0]        cnt_next;

    logic                             dig;
    logic [3:0]                       d;
    logic [dip_pkg::MAG_W+3:0]        mag_sum;
    logic                             ovf;
    logic [dip_pkg::CNT_W-1:0]        cnt_inc;
    dip_pkg::result_t                 fail_res;

    function automatic dip_pkg::result_t finish(
        input logic [dip_pkg::MAG_W-1:0] mag,
        input logic [dip_pkg::CNT_W-1:0] cnt,
        input logic                      neg
    );
        dip_pkg::result_t r;
        logic             in_range;
        in_range   = neg ? (mag <= dip_pkg::MAG_NEG_MAX) : (mag <= dip_pkg::MAG_POS_MAX);
        r.ok       = in_range;
        r.neg      = in_range & neg;
        r.mag      = in_range ? mag : '0;
        r.consumed = in_range ? (cnt + {{(dip_pkg::CNT_W-1){1'b0}}, neg}) : '0;
        return r;
    endfunction

    assign dig  = (item.data >= dip_pkg::CH_ZERO) && (item.data <= dip_pkg::CH_NINE);
    assign d    = 4'(item.data - dip_pkg::CH_ZERO);
    // magnitude * 10 + digit, kept wide so overflow shows in the top bits
    assign mag_sum = {3'b000, mag_reg, 1'b0} + {1'b0, mag_reg, 3'b000}
                   + {{dip_pkg::MAG_W{1'b0}}, d};
    assign ovf     = |mag_sum[dip_pkg::MAG_W+3:dip_pkg::MAG_W];
    assign cnt_inc = cnt_reg + 5'd1;

    always_comb
    begin
        fail_res          = '0;
        phase_next        = phase_reg;
        mag_next          = mag_reg;
        neg_next          = neg_reg;
        cnt_next          = cnt_reg;
        emit              = 1'b0;
        res               = fail_res;

        unique case (phase_reg)
            dip_pkg::PH_START,
            dip_pkg::PH_SIGN:
            begin
                if (phase_reg == dip_pkg::PH_START && item.data == dip_pkg::CH_MINUS)
                begin
                    if (item.last)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        neg_next   = 1'b1;
                        phase_next = dip_pkg::PH_SIGN;
                    end
                end
                else if (dig && d == 4'd0)
                begin
                    if (item.last)
                    begin
                        emit = 1'b1;
                        res  = finish('0, 5'd1, neg_reg);
                    end
                    else
                    begin
                        phase_next = dip_pkg::PH_ZERO;
                    end
                end
                else if (dig)
                begin
                    if (item.last)
                    begin
                        emit = 1'b1;
                        res  = finish({{(dip_pkg::MAG_W-4){1'b0}}, d}, 5'd1, neg_reg);
                    end
                    else
                    begin
                        mag_next   = {{(dip_pkg::MAG_W-4){1'b0}}, d};
                        cnt_next   = 5'd1;
                        phase_next = dip_pkg::PH_DIGITS;
                    end
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            dip_pkg::PH_ZERO:
            begin
                if (!dig)
                begin
                    emit = 1'b1;
                    res  = finish('0, 5'd1, neg_reg);
                end
                else if (item.last)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    phase_next = dip_pkg::PH_FAILWAIT;
                end
            end
            dip_pkg::PH_DIGITS:
            begin
                if (!dig)
                begin
                    emit = 1'b1;
                    res  = finish(mag_reg, cnt_reg, neg_reg);
                end
                else if (cnt_reg >= dip_pkg::MAX_DIGITS || ovf)
                begin
                    if (item.last)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        cnt_next   = dip_pkg::MAX_DIGITS + 5'd1;
                        phase_next = dip_pkg::PH_FAILWAIT;
                    end
                end
                else if (item.last)
                begin
                    emit = 1'b1;
                    res  = finish(mag_sum[dip_pkg::MAG_W-1:0], cnt_inc, neg_reg);
                end
                else
                begin
                    mag_next = mag_sum[dip_pkg::MAG_W-1:0];
                    cnt_next = cnt_inc;
                end
            end
            dip_pkg::PH_FAILWAIT:
            begin
                if (!dig || item.last)
                begin
                    emit = 1'b1;
                end
            end
            default:
            begin
                if (item.last)
                begin
                    phase_next = dip_pkg::PH_START;
                    mag_next   = '0;
                    neg_next   = 1'b0;
                    cnt_next   = '0;
                end
            end
        endcase

        // Any result clears the number and, unless its byte was the last, waits for the end of the buffer.
        if (emit)
        begin
            mag_next   = '0;
            neg_next   = 1'b0;
            cnt_next   = '0;
            phase_next = item.last ? dip_pkg::PH_START : dip_pkg::PH_SKIP;
        end

        emit = emit && item_valid;
    end

    // Bytes that give no result move on even while a result is stalled.
    assign advance = item_valid && (!emit || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dip_pkg::PH_START;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            cnt_reg   <= cnt_next;
        end
    end

    `DIP_ASSERT(a_skip_clean, phase_reg == dip_pkg::PH_SKIP |-> mag_reg == '0 && cnt_reg == '0 && !neg_reg)
    `DIP_ASSERT(a_cnt_bound, cnt_reg <= dip_pkg::MAX_DIGITS + 5'd1)
    `DIP_ASSERT(a_hold_on_stall, item_valid && !advance |=> $stable(phase_reg) && $stable(mag_reg))
    `DIP_ASSERT(a_stall_only_emit, item_valid && !advance |-> emit && !out_free)

endmodule

`default_nettype wire

>>> rtl/core/dip_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module dip_out_reg
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire dip_pkg::result_t       res,
    input  wire logic                   out_ready,
    output logic                        out_free,
    output logic                        out_valid,
    output logic                        ok,
    output logic signed [63:0]          value,
    output logic [4:0]                  consumed
);

    logic             valid_reg;
    logic             valid_next;
    dip_pkg::result_t res_reg;

    assign out_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    // Sign applied on the way out; magnitude is held unsigned.
    assign out_valid = valid_reg;
    assign ok        = res_reg.ok;
    assign value     = res_reg.neg ? $signed(64'd0 - res_reg.mag) : $signed(res_reg.mag);
    assign consumed  = res_reg.consumed;

endmodule

`default_nettype wire

>>> rtl/core/decimal_int64_parser_top.sv
// Decimal int64 parser.
// Input channel (in_valid/in_ready): one text byte per transaction in byte_in, with
// end_of_buffer marking the last byte of a buffer. Output channel (out_valid/out_ready):
// one result per buffer with ok, value (two's complement, zero on failure) and consumed.
// A result comes at the first byte that is not part of the number or at the last byte;
// remaining bytes of that buffer are dropped without a result.
// Throughput: one byte per cycle unless a result waits on out_ready, set by the single
// multiply-by-ten, add and range check stage between the input register and the result
// register; a result enters the result register as its byte leaves the input register.
// While a result waits on out_ready, bytes that give no result keep flowing; a byte
// that would give a result holds in the input register, and in_ready drops.
// Reset empties both registers and returns the parser to the start of a buffer.
`timescale 1ns / 1ps
`default_nettype none
`include "decimal_int64_parser_top_defines.svh"

module decimal_int64_parser_top
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         byte_in,
    input  wire logic               end_of_buffer,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    ok,
    output logic signed [63:0]      value,
    output logic [4:0]              consumed
);

    logic             item_valid;
    dip_pkg::item_t   item;
    logic             advance;
    logic             emit;
    logic             out_free;
    dip_pkg::result_t res;

    dip_in_reg u_in_reg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .byte_in       (byte_in),
        .end_of_buffer (end_of_buffer),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    dip_parse u_parse
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .advance    (advance),
        .emit       (emit),
        .res        (res)
    );

    dip_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && emit),
        .res       (res),
        .out_ready (out_ready),
        .out_free  (out_free),
        .out_valid (out_valid),
        .ok        (ok),
        .value     (value),
        .consumed  (consumed)
    );

    `DIP_ASSERT_ALWAYS(a_no_out_in_reset, !rst_n |-> !out_valid)
    `DIP_ASSERT(a_fail_zero, out_valid && !ok |-> value == 64'sd0 && consumed == 5'd0)
    `DIP_ASSERT(a_ok_consumed, out_valid && ok |-> consumed != 5'd0 && consumed <= 5'd21)

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 100;
    localparam int STAGE_BYTES = 250;

    typedef struct packed {
        logic               ok;
        logic signed [63:0] value;
        logic [4:0]         consumed;
    } int64_parse_t;

    // Tracks the parse state byte by byte and holds the numbers still owed by the block.
    class int64_parse_checker;
        int64_parse_t     pending_numbers[$];
        int unsigned      fail_count;
        logic [63:0]      mag;
        logic             neg;
        logic [4:0]       ndig;
        dip_pkg::phase_t  ph;

        function new();
            clear_number();
            ph = dip_pkg::PH_START;
            fail_count = 0;
        endfunction

        function void clear_number();
            mag  = '0;
            neg  = 1'b0;
            ndig = '0;
        endfunction

        function void post_number(logic okv, logic [63:0] val, logic [4:0] cons, logic last);
            int64_parse_t r;
            r.ok       = okv;
            r.value    = okv ? val : '0;
            r.consumed = okv ? cons : '0;
            pending_numbers.push_back(r);
            clear_number();
            ph = last ? dip_pkg::PH_START : dip_pkg::PH_SKIP;
        endfunction

        // Range check of a finished run of digits; 2^63 passes only with a sign.
        function void close_digits(logic last);
            logic [4:0] cons;
            cons = ndig + {4'd0, neg};
            if (neg) begin
                if (mag > dip_pkg::MAG_NEG_MAX)
                    post_number(1'b0, '0, '0, last);
                else
                    post_number(1'b1, 64'd0 - mag, cons, last);
            end
            else if (mag > dip_pkg::MAG_POS_MAX)
                post_number(1'b0, '0, '0, last);
            else
                post_number(1'b1, mag, cons, last);
        endfunction

        function void lead_digit(logic [7:0] b, logic last);
            if (b == dip_pkg::CH_ZERO) begin
                if (last)
                    post_number(1'b1, '0, 5'd1 + {4'd0, neg}, 1'b1);
                else
                    ph = dip_pkg::PH_ZERO;
            end
            else begin
                mag  = {56'd0, b - dip_pkg::CH_ZERO};
                ndig = 5'd1;
                ph   = dip_pkg::PH_DIGITS;
                if (last)
                    close_digits(1'b1);
            end
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            logic        dec_byte;
            logic [63:0] d;
            dec_byte = (b >= dip_pkg::CH_ZERO) && (b <= dip_pkg::CH_NINE);
            d = {56'd0, b - dip_pkg::CH_ZERO};
            case (ph)
                dip_pkg::PH_START:
                    if (b == dip_pkg::CH_MINUS) begin
                        neg = 1'b1;
                        if (last)
                            post_number(1'b0, '0, '0, 1'b1);
                        else
                            ph = dip_pkg::PH_SIGN;
                    end
                    else if (dec_byte)
                        lead_digit(b, last);
                    else
                        post_number(1'b0, '0, '0, last);
                dip_pkg::PH_SIGN:
                    if (dec_byte)
                        lead_digit(b, last);
                    else
                        post_number(1'b0, '0, '0, last);
                dip_pkg::PH_ZERO:
                    if (!dec_byte)
                        post_number(1'b1, '0, 5'd1 + {4'd0, neg}, last);
                    else if (last)
                        post_number(1'b0, '0, '0, 1'b1);
                    else
                        ph = dip_pkg::PH_FAILWAIT;
                dip_pkg::PH_DIGITS:
                    if (!dec_byte)
                        close_digits(last);
                    else if (ndig >= dip_pkg::MAX_DIGITS ||
                             mag > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) begin
                        // hold the failure until the number ends
                        if (last)
                            post_number(1'b0, '0, '0, 1'b1);
                        else begin
                            ndig = dip_pkg::MAX_DIGITS + 5'd1;
                            ph   = dip_pkg::PH_FAILWAIT;
                        end
                    end
                    else begin
                        mag  = mag * 64'd10 + d;
                        ndig = ndig + 5'd1;
                        if (last)
                            close_digits(1'b1);
                    end
                dip_pkg::PH_FAILWAIT:
                    if (!dec_byte || last)
                        post_number(1'b0, '0, '0, last);
                default:
                    if (last) begin
                        clear_number();
                        ph = dip_pkg::PH_START;
                    end
            endcase
        endfunction

        function void match_number(logic okv, logic signed [63:0] v, logic [4:0] cons);
            int64_parse_t want;
            if (pending_numbers.size() == 0) begin
                $error("unexpected result: ok %0d value %0d consumed %0d", okv, v, cons);
                fail_count++;
                return;
            end
            want = pending_numbers.pop_front();
            if (okv !== want.ok) begin
                $error("ok: expected %0d, actual %0d", want.ok, okv);
                fail_count++;
            end
            if (v !== want.value) begin
                $error("value: expected %0d, actual %0d", want.value, v);
                fail_count++;
            end
            if (cons !== want.consumed) begin
                $error("consumed: expected %0d, actual %0d", want.consumed, cons);
                fail_count++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         byte_in;
    logic               end_of_buffer;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               ok;
    logic signed [63:0] value;
    logic [4:0]         consumed;

    int64_parse_checker parse_check;
    logic [7:0]         text[$];
    int                 bytes_counted = 0;
    int                 snd_idle_pct = 15;
    int                 rcv_idle_pct = 88;
    int                 hold_asks = 0;
    int                 holds_taken = 0;
    int                 hold_left = 0;
    int                 quiet_cycles = 0;

    string boundary_texts[0:13] = '{
        "9223372036854775807", "-9223372036854775808", "9223372036854775808",
        "-9223372036854775809", "18446744073709551615", "18446744073709551616",
        "99999999999999999999", "100000000000000000000", "12345678901234567890123",
        "-0", "0", "-", "-00", "007"
    };

    decimal_int64_parser_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .byte_in       (byte_in),
        .end_of_buffer (end_of_buffer),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ok            (ok),
        .value         (value),
        .consumed      (consumed)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                parse_check.take_byte(byte_in, end_of_buffer);
            if (out_valid && out_ready)
                parse_check.match_number(ok, value, consumed);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles == STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random back-pressure, plus a long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_asks != holds_taken) begin
            holds_taken <= holds_taken + 1;
            hold_left   <= LONG_HOLD;
            out_ready   <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic put_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        byte_in       <= b;
        end_of_buffer <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text.size(); i++)
            put_byte(text[i], i == text.size() - 1);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endtask

    task automatic send_directed();
        string cases[0:10] = '{"0", "-0", "05", "-", "--", "-a", "7", "42 9", "0:", "9/", ":"};
        foreach (cases[i]) begin
            text.delete();
            add_str(cases[i]);
            bytes_counted += text.size();
            send_text();
        end
        text = '{8'hFF};
        send_text();
        text = '{8'h00};
        send_text();
        bytes_counted += 2;
    endtask

    // Mostly well-formed numbers with random content, some boundary values and noise.
    task automatic make_random_text();
        int         kind;
        int         n;
        logic [7:0] b;
        text.delete();
        kind = $urandom_range(99);
        if (kind < 12) begin
            n = $urandom_range(1, 6);
            repeat (n)
                text.push_back(8'($urandom_range(255)));
        end
        else if (kind < 24)
            add_str(boundary_texts[$urandom_range(13)]);
        else begin
            if ($urandom_range(2) == 0)
                text.push_back(dip_pkg::CH_MINUS);
            n = ($urandom_range(9) == 0) ? $urandom_range(9, 22) : $urandom_range(1, 8);
            if ($urandom_range(9) == 0)
                text.push_back(dip_pkg::CH_ZERO);
            else
                text.push_back(dip_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
            repeat (n - 1)
                text.push_back(dip_pkg::CH_ZERO + 8'($urandom_range(9)));
        end
        if ($urandom_range(1) == 1) begin
            do
                b = 8'($urandom_range(255));
            while (b >= dip_pkg::CH_ZERO && b <= dip_pkg::CH_NINE);
            text.push_back(b);
            repeat ($urandom_range(4))
                text.push_back(8'($urandom_range(255)));
        end
        bytes_counted += text.size();
    endtask

    initial
    begin
        int target;
        bit paused;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        byte_in       = '0;
        end_of_buffer = 1'b0;
        parse_check   = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_directed();
        for (int stage = 0; stage < 3; stage++) begin
            case (stage)
                0: begin snd_idle_pct = 15; rcv_idle_pct = 88; end
                1: begin snd_idle_pct = 88; rcv_idle_pct = 15; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            // last stage: stall the result side so the block backs up its input
            if (stage == 2)
                hold_asks++;
            target = bytes_counted + STAGE_BYTES;
            paused = 1'b0;
            while (bytes_counted < target) begin
                if (stage == 2 && !paused && bytes_counted >= target - STAGE_BYTES / 2) begin
                    in_valid <= 1'b0;
                    do
                        @(negedge clk);
                    while (parse_check.pending_numbers.size() != 0);
                    paused = 1'b1;
                end
                make_random_text();
                send_text();
            end
        end

        in_valid <= 1'b0;
        while (parse_check.pending_numbers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (parse_check.fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
